// File: rtl/core/rfft_pkg.sv
package rfft_pkg;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILL,
    ST_UNTANGLE,
    ST_BFLY,
    ST_OUT
  } seq_state_t;

  // micro-step within one butterfly, untangle or output step
  typedef enum logic [2:0] {
    PH_ISSUE,
    PH_FETCH,
    PH_MULT,
    PH_SUM,
    PH_WRA,
    PH_WRB
  } phase_t;

  // classification of one queued input beat
  typedef struct packed {
    logic inv;   // frame is an inverse transform
    logic keep;  // beat fits in the frame and is stored
    logic fin;   // last beat of the frame
  } item_ctrl_t;

  // sin(pi*k/32) scaled by 2^23, k = 0..16
  localparam int QSINE [17] = '{
    0, 822227, 1636536, 2435084, 3210181, 3954362, 4660461, 5321677,
    5931642, 6484482, 6974873, 7398092, 7750063, 8027397, 8227423, 8348215,
    8388608
  };

endpackage

// File: rtl/core/rfft_front.sv
module rfft_front #(
  parameter int W    = 24,
  parameter int HALF = 32,
  parameter int IW   = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic signed [W-1:0]       first_value,
  input  logic signed [W-1:0]       second_value,
  input  logic                      frame_end,
  output logic                      q_valid,
  input  logic                      q_ready,
  output rfft_pkg::item_ctrl_t      q_ctrl,
  output logic [IW-1:0]             q_idx,
  output logic signed [W-1:0]       q_first,
  output logic signed [W-1:0]       q_second
);
  import rfft_pkg::*;

  localparam int QD = 4;
  localparam int QA = 2;

  logic [IW-1:0]   cnt;
  logic            dir;
  logic            dir_eff;
  logic            keep;
  logic            push;
  logic            pop;
  logic [QA-1:0]   wp;
  logic [QA-1:0]   rp;
  logic [QA:0]     fill;

  item_ctrl_t        qc_mem [QD];
  logic [IW-1:0]     qi_mem [QD];
  logic signed [W-1:0] qf_mem [QD];
  logic signed [W-1:0] qs_mem [QD];

  // classify the beat: direction from the first beat, drop past capacity
  always_comb begin
    dir_eff = (cnt == IW'(0)) ? kind : dir;
    keep    = cnt < (dir_eff ? IW'(HALF + 1) : IW'(HALF));
  end

  assign in_ready = (fill != (QA + 1)'(QD));
  assign q_valid  = (fill != (QA + 1)'(0));
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // frame position and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      dir  <= 1'b0;
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        dir <= dir_eff;
        if (frame_end) begin
          cnt <= '0;
        end else if (keep) begin
          cnt <= cnt + IW'(1);
        end
        wp <= wp + QA'(1);
      end
      if (pop) begin
        rp <= rp + QA'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QA + 1)'(1);
      end else if (!push && pop) begin
        fill <= fill - (QA + 1)'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qc_mem[wp] <= '{inv: dir_eff, keep: keep, fin: frame_end};
      qi_mem[wp] <= cnt;
      qf_mem[wp] <= first_value;
      qs_mem[wp] <= second_value;
    end
  end

  assign q_ctrl   = qc_mem[rp];
  assign q_idx    = qi_mem[rp];
  assign q_first  = qf_mem[rp];
  assign q_second = qs_mem[rp];

endmodule

// File: rtl/core/rfft_back.sv
module rfft_back #(
  parameter int W      = 24,
  parameter int T      = 16,
  parameter int POINTS = 64,
  parameter int IW     = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  rfft_pkg::item_ctrl_t      q_ctrl,
  input  logic [IW-1:0]             q_idx,
  input  logic signed [W-1:0]       q_first,
  input  logic signed [W-1:0]       q_second,
  output logic                      o_valid,
  input  logic                      o_ready,
  output logic signed [W-1:0]       o_first,
  output logic signed [W-1:0]       o_second,
  output logic                      o_last
);
  import rfft_pkg::*;

  localparam int HALF = POINTS / 2;
  localparam int LG   = $clog2(HALF);
  localparam int SW   = $clog2(LG);
  localparam int SS   = 6 - $clog2(POINTS);
  localparam int A    = W + 7;
  localparam int A1   = A + 1;
  localparam int P    = A + T;
  localparam int WW   = P + 2;
  localparam int SH   = 24 - T;
  localparam int TRND = (SH > 0) ? (1 << (SH - 1)) : 0;
  localparam int TMAX = (1 << (T - 1)) - 1;
  localparam int TMIN = -TMAX - 1;

  localparam logic signed [WW-1:0] AHI = {{(WW - A + 1){1'b0}}, {(A - 1){1'b1}}};
  localparam logic signed [WW-1:0] ALO = ~AHI;
  localparam logic signed [WW-1:0] DHI = {{(WW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [WW-1:0] DLO = ~DHI;
  localparam logic signed [WW-1:0] RT  = {{(WW - T + 1){1'b0}}, 1'b1, {(T - 2){1'b0}}};
  localparam logic signed [WW-1:0] RL  = {{(WW - LG){1'b0}}, 1'b1, {(LG - 1){1'b0}}};
  localparam logic signed [WW-1:0] R1  = {{(WW - 1){1'b0}}, 1'b1};

  function automatic logic signed [A-1:0] sat_a(input logic signed [WW-1:0] x);
    if (x > AHI) return AHI[A-1:0];
    if (x < ALO) return ALO[A-1:0];
    return x[A-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_d(input logic signed [WW-1:0] x);
    if (x > DHI) return DHI[W-1:0];
    if (x < DLO) return DLO[W-1:0];
    return x[W-1:0];
  endfunction

  function automatic logic signed [A-1:0] neg_a(input logic signed [A-1:0] v);
    if (v == ALO[A-1:0]) return AHI[A-1:0];
    return -v;
  endfunction

  function automatic logic signed [WW-1:0] rnd_t(input logic signed [WW-1:0] x);
    return (x + RT) >>> (T - 1);
  endfunction

  function automatic logic signed [WW-1:0] rnd1(input logic signed [WW-1:0] x);
    return (x + R1) >>> 1;
  endfunction

  function automatic logic signed [WW-1:0] rnd_lg(input logic signed [WW-1:0] x);
    return (x + RL) >>> LG;
  endfunction

  function automatic logic [LG-1:0] rev(input logic [LG-1:0] v);
    logic [LG-1:0] r;
    for (int i = 0; i < LG; i++) r[i] = v[LG - 1 - i];
    return r;
  endfunction

  // exp(-2*pi*i*m/64) as {cos, -sin}
  function automatic logic [2*T-1:0] twid(input logic [5:0] m);
    logic [4:0] ri;
    logic [4:0] rc;
    int cv;
    int sv;
    int cr;
    int sr;
    ri = {1'b0, m[3:0]};
    rc = 5'd16 - ri;
    case (m[5:4])
      2'd0: begin cv = QSINE[rc];  sv = QSINE[ri];  end
      2'd1: begin cv = -QSINE[ri]; sv = QSINE[rc];  end
      2'd2: begin cv = -QSINE[rc]; sv = -QSINE[ri]; end
      default: begin cv = QSINE[ri]; sv = -QSINE[rc]; end
    endcase
    cr = (cv + TRND) >>> SH;
    sr = (-sv + TRND) >>> SH;
    if (cr > TMAX) cr = TMAX;
    if (cr < TMIN) cr = TMIN;
    if (sr > TMAX) sr = TMAX;
    if (sr < TMIN) sr = TMIN;
    return {T'(cr), T'(sr)};
  endfunction

  seq_state_t state;
  seq_state_t state_next;
  phase_t     ph;
  phase_t     ph_next;

  logic [IW-1:0]   k;
  logic [SW-1:0]   s;
  logic [LG-2:0]   bc;
  logic            inv;
  logic [IW-1:0]   cap;

  logic [LG-1:0]   bx;
  logic [LG-1:0]   msk;
  logic [LG-1:0]   jv;
  logic [LG-1:0]   aidx;
  logic [LG-1:0]   bidx;
  logic            bc_last;
  logic            s_last;
  logic            last_now;
  logic            fedge;
  logic            out_load;
  logic [5:0]      tw_m;

  // work buffer: two banks of 2^IW complex entries
  logic [2*A-1:0]  mem [2 ** (IW + 1)];
  logic [2*A-1:0]  rd0;
  logic [2*A-1:0]  rd1;
  logic [IW:0]     ra0;
  logic [IW:0]     ra1;
  logic [IW:0]     waddr;
  logic [2*A-1:0]  wdata;
  logic            we;

  logic signed [A-1:0]  x_re;
  logic signed [A-1:0]  x_im;
  logic signed [A-1:0]  m_re;
  logic signed [A-1:0]  m_im;
  logic signed [A1-1:0] pre1;
  logic signed [A1-1:0] pre2;
  logic signed [A-1:0]  mx;
  logic signed [A-1:0]  my;
  logic signed [T-1:0]  cw;
  logic signed [T-1:0]  sw;
  logic signed [P-1:0]  pxc;
  logic signed [P-1:0]  pys;
  logic signed [P-1:0]  pxs;
  logic signed [P-1:0]  pyc;
  logic signed [WW-1:0] vr;
  logic signed [WW-1:0] vi;
  logic signed [WW-1:0] tr;
  logic signed [WW-1:0] ti;
  logic signed [A-1:0]  res0re;
  logic signed [A-1:0]  res0im;
  logic signed [A-1:0]  res1re;
  logic signed [A-1:0]  res1im;

  assign cap     = inv ? IW'(HALF + 1) : IW'(HALF);
  assign q_ready = (state == ST_LOAD);

  // butterfly addressing from the pair count and stage
  always_comb begin
    bx      = LG'(bc);
    msk     = (LG'(1) << s) - LG'(1);
    jv      = bx & msk;
    aidx    = ((bx & ~msk) << 1) | jv;
    bidx    = aidx | (LG'(1) << s);
    bc_last = (bc == '1);
    s_last  = (s == SW'(LG - 1));
    last_now = inv ? (k == IW'(HALF - 1)) : (k == IW'(HALF));
    fedge    = (k == IW'(0)) || (k == IW'(HALF));
    out_load = (state == ST_OUT) && (ph == PH_SUM) && (!o_valid || o_ready);
    tw_m     = (state == ST_BFLY) ? (6'(jv) << (6'd5 - 6'(s))) : (6'(k) << SS);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (q_valid && q_ctrl.fin) state_next = ST_FILL;
      ST_FILL: if (k >= cap) state_next = inv ? ST_UNTANGLE : ST_BFLY;
      ST_UNTANGLE: if (ph == PH_WRA && k == IW'(HALF - 1)) state_next = ST_BFLY;
      ST_BFLY: if (ph == PH_WRB && bc_last && s_last) state_next = ST_OUT;
      ST_OUT: if (out_load && last_now) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // next micro-step
  always_comb begin
    ph_next = PH_ISSUE;
    unique case (ph)
      PH_ISSUE: if (state == ST_UNTANGLE || state == ST_BFLY || state == ST_OUT)
                  ph_next = PH_FETCH;
      PH_FETCH: ph_next = PH_MULT;
      PH_MULT:  ph_next = PH_SUM;
      PH_SUM: begin
        if (state == ST_OUT) ph_next = out_load ? PH_ISSUE : PH_SUM;
        else ph_next = PH_WRA;
      end
      PH_WRA: ph_next = (state == ST_BFLY) ? PH_WRB : PH_ISSUE;
      PH_WRB: ph_next = PH_ISSUE;
      default: ph_next = PH_ISSUE;
    endcase
  end

  // memory addresses and writes
  always_comb begin
    ra0   = '0;
    ra1   = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      ST_LOAD: begin
        we    = q_valid && q_ctrl.keep;
        waddr = q_ctrl.inv ? {1'b0, q_idx} : {1'b1, IW'(rev(q_idx[LG-1:0]))};
        wdata = {A'(q_second), A'(q_first)};
      end
      ST_FILL: begin
        we    = (k < cap);
        waddr = inv ? {1'b0, k} : {1'b1, IW'(rev(k[LG-1:0]))};
      end
      ST_UNTANGLE: begin
        ra0   = {1'b0, k};
        ra1   = {1'b0, IW'(HALF) - k};
        we    = (ph == PH_WRA);
        waddr = {1'b1, IW'(rev(k[LG-1:0]))};
        wdata = {neg_a(res0im), res0re};
      end
      ST_BFLY: begin
        ra0   = {1'b1, IW'(aidx)};
        ra1   = {1'b1, IW'(bidx)};
        we    = (ph == PH_WRA) || (ph == PH_WRB);
        waddr = (ph == PH_WRB) ? ra1 : ra0;
        wdata = (ph == PH_WRB) ? {res1im, res1re} : {res0im, res0re};
      end
      ST_OUT: begin
        ra0 = {1'b1, (k == IW'(HALF)) ? IW'(0) : k};
        ra1 = {1'b1, (k == IW'(0)) ? IW'(0) : IW'(HALF) - k};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  assign x_re = rd0[A-1:0];
  assign x_im = rd0[2*A-1:A];
  assign m_re = rd1[A-1:0];
  assign m_im = rd1[2*A-1:A];

  // product combinations
  always_comb begin
    vr = rnd_t(WW'(pxc) - WW'(pys));
    vi = rnd_t(WW'(pxs) + WW'(pyc));
    tr = rnd_t(WW'(pxc) + WW'(pys));
    ti = rnd_t(WW'(pyc) - WW'(pxs));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      ph      <= PH_ISSUE;
      k       <= '0;
      s       <= '0;
      bc      <= '0;
      inv     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      case (state)
        ST_LOAD: begin
          if (q_valid && q_ctrl.fin) begin
            k   <= q_ctrl.keep ? q_idx + IW'(1) : q_idx;
            inv <= q_ctrl.inv;
          end
        end
        ST_FILL: begin
          if (k < cap) begin
            k <= k + IW'(1);
          end else begin
            k  <= '0;
            s  <= '0;
            bc <= '0;
          end
        end
        ST_UNTANGLE: begin
          if (ph == PH_WRA) k <= (k == IW'(HALF - 1)) ? IW'(0) : k + IW'(1);
        end
        ST_BFLY: begin
          if (ph == PH_WRB) begin
            bc <= bc + 1'b1;
            if (bc_last) begin
              if (s_last) k <= '0;
              else s <= s + SW'(1);
            end
          end
        end
        ST_OUT: begin
          if (out_load) k <= k + IW'(1);
        end
        default: ;
      endcase
      if (out_load) o_valid <= 1'b1;
      else if (o_ready) o_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ph == PH_FETCH) begin
      {cw, sw} <= twid(tw_m);
      case (state)
        ST_UNTANGLE: begin
          pre1 <= A1'(sat_a(WW'(x_re) + WW'(m_re)));
          pre2 <= A1'(sat_a(WW'(x_im) - WW'(m_im)));
          mx   <= sat_a(WW'(x_re) - WW'(m_re));
          my   <= sat_a(WW'(x_im) + WW'(m_im));
        end
        ST_BFLY: begin
          pre1 <= A1'(x_re);
          pre2 <= A1'(x_im);
          mx   <= m_re;
          my   <= m_im;
        end
        ST_OUT: begin
          if (inv) begin
            pre1 <= A1'(x_re);
            pre2 <= A1'(neg_a(x_im));
          end else if (k == IW'(0)) begin
            pre1 <= A1'(x_re) + A1'(x_im);
          end else if (k == IW'(HALF)) begin
            pre1 <= A1'(x_re) - A1'(x_im);
          end else begin
            pre1 <= A1'(sat_a(WW'(x_re) + WW'(m_re)));
            pre2 <= A1'(sat_a(WW'(x_im) - WW'(m_im)));
            mx   <= sat_a(WW'(x_im) + WW'(m_im));
            my   <= sat_a(WW'(m_re) - WW'(x_re));
          end
        end
        default: ;
      endcase
    end
    if (ph == PH_MULT) begin
      pxc <= mx * cw;
      pys <= my * sw;
      pxs <= mx * sw;
      pyc <= my * cw;
    end
    if (ph == PH_SUM) begin
      case (state)
        ST_UNTANGLE: begin
          res0re <= sat_a(rnd1(WW'(pre1) - ti));
          res0im <= sat_a(rnd1(WW'(pre2) + tr));
        end
        ST_BFLY: begin
          res0re <= sat_a(WW'(pre1) + vr);
          res0im <= sat_a(WW'(pre2) + vi);
          res1re <= sat_a(WW'(pre1) - vr);
          res1im <= sat_a(WW'(pre2) - vi);
        end
        ST_OUT: begin
          if (out_load) begin
            o_last <= last_now;
            if (inv) begin
              o_first  <= sat_d(rnd_lg(WW'(pre1)));
              o_second <= sat_d(rnd_lg(WW'(pre2)));
            end else if (fedge) begin
              o_first  <= sat_d(WW'(pre1));
              o_second <= '0;
            end else begin
              o_first  <= sat_d(rnd1(WW'(pre1) + vr));
              o_second <= sat_d(rnd1(WW'(pre2) + vi));
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/real_fft_forward_inverse.sv
// Real FFT of POINTS samples, forward or inverse, through a half-length
// complex radix-2 transform in fixed point. A forward frame is POINTS/2 input
// beats of (even, odd) sample pairs and gives POINTS/2+1 bins; an inverse
// frame is POINTS/2+1 bin beats and gives POINTS/2 sample pairs. The kind of
// the first beat sets the direction, tlast ends the frame, extra beats are
// dropped and missing ones count as zero. Input beats go into a four-entry
// queue at one per cycle while it has room; one shared complex multiplier
// and a single write port on the work buffer then set the frame time,
// which goes through closing the load, zero-filling the missing beats of a
// short frame, the untangle bins (inverse only), the butterflies
// (POINTS/4 * log2(POINTS/2) of them) and the result beats, in that order.
// Results sit in an output register, so a new frame loads while the last
// result of the previous one waits to be taken.
module real_fft_forward_inverse #(
  parameter int POINTS        = 64,
  parameter int DATA_WIDTH    = 24,
  parameter int TWIDDLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // first_value, second_value
  input  logic                  s_tlast,                // frame_end
  input  logic                  s_tuser,                // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,  // out_first, out_second
  output logic                  m_tlast                 // out_last
);
  import rfft_pkg::*;

  localparam int HALF = POINTS / 2;
  localparam int IW   = $clog2(HALF + 1);
  localparam int TDW  = ((2 * DATA_WIDTH + 7) / 8) * 8;

  logic                         q_valid;
  logic                         q_ready;
  item_ctrl_t                   q_ctrl;
  logic [IW-1:0]                q_idx;
  logic signed [DATA_WIDTH-1:0] q_first;
  logic signed [DATA_WIDTH-1:0] q_second;
  logic signed [DATA_WIDTH-1:0] o_first;
  logic signed [DATA_WIDTH-1:0] o_second;

  // input classification and queue
  rfft_front #(
    .W    (DATA_WIDTH),
    .HALF (HALF),
    .IW   (IW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .kind         (s_tuser),
    .first_value  (s_tdata[DATA_WIDTH-1:0]),
    .second_value (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .frame_end    (s_tlast),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_ctrl       (q_ctrl),
    .q_idx        (q_idx),
    .q_first      (q_first),
    .q_second     (q_second)
  );

  // transform sequencer, work buffer and output register
  rfft_back #(
    .W      (DATA_WIDTH),
    .T      (TWIDDLE_WIDTH),
    .POINTS (POINTS),
    .IW     (IW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_ctrl   (q_ctrl),
    .q_idx    (q_idx),
    .q_first  (q_first),
    .q_second (q_second),
    .o_valid  (m_tvalid),
    .o_ready  (m_tready),
    .o_first  (o_first),
    .o_second (o_second),
    .o_last   (m_tlast)
  );

  assign m_tdata = TDW'({o_second, o_first});

endmodule
